FILE: rtl/core/harmonic_grid_cell_update_top_defines.svh
// ----------------------------------------------------------------------------
// Harmonic grid cell update: assertion macros
// Shared concurrent assertion forms used by the core modules.
// ----------------------------------------------------------------------------
`ifndef HARMONIC_GRID_CELL_UPDATE_TOP_DEFINES_SVH
`define HARMONIC_GRID_CELL_UPDATE_TOP_DEFINES_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define HGC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hgc implication check failed");

// The condition holds at every clock edge outside reset.
`define HGC_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("hgc invariant check failed");

`endif

FILE: rtl/core/hgc_pkg.sv
// ----------------------------------------------------------------------------
// Harmonic grid cell update: package
// Word types, register indexes and Q8.24 rounding and saturation helpers.
// ----------------------------------------------------------------------------
package hgc_pkg;

    localparam int DATA_W    = 32;
    localparam int HARM_W    = 6;
    localparam int DT_W      = 25;
    localparam int COS_W     = 26;
    localparam int XI_W      = 40;
    localparam int NUM_W     = 64;
    localparam int QUO_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int WIDE_W    = 72;

    localparam logic [DT_W-1:0]         DT_RESET  = 25'd16777;
    localparam logic signed [COS_W-1:0] COS_RESET = 26'sd16777216;
    localparam logic [XI_W-1:0]         XI_MIN    = 40'd16777216;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_E_DC          = 3'd0,
        CFG_E_OMEGA       = 3'd1,
        CFG_B_FIELD       = 3'd2,
        CFG_TIME_STEP     = 3'd3,
        CFG_GRID_COUPLING = 3'd4,
        CFG_COS_NOW       = 3'd5,
        CFG_COS_NEXT      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [HARM_W-1:0]        harmonic;
        logic signed [DATA_W-1:0] phi_coord;
        logic signed [DATA_W-1:0] source_amp;
        logic signed [DATA_W-1:0] cur_a;
        logic signed [DATA_W-1:0] cur_b;
        logic signed [DATA_W-1:0] diff_b_upper;
        logic signed [DATA_W-1:0] diff_b_lower;
        logic signed [DATA_W-1:0] diff_a_lower;
        logic signed [DATA_W-1:0] diff_a_upper;
    } t_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] new_a;
        logic signed [DATA_W-1:0] new_b;
        logic                     new_b_valid;
    } t_res;

    // Round half up, then drop 24 or 25 fraction bits.
    function automatic logic signed [WIDE_W-1:0] rnd24(input logic signed [WIDE_W-1:0] p);
        return (p + 72'sd8388608) >>> 24;
    endfunction

    function automatic logic signed [WIDE_W-1:0] rnd25(input logic signed [WIDE_W-1:0] p);
        return (p + 72'sd16777216) >>> 25;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] p);
        logic signed [DATA_W-1:0] r;
        if (p > 72'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (p < -72'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = p[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/hgc_div.sv
// ----------------------------------------------------------------------------
// Harmonic grid cell update: pipelined divider
// Signed 64-bit by unsigned 40-bit division, rounded to nearest with ties
// away from zero and saturated to 32 bits, one quotient bit per stage.
// ----------------------------------------------------------------------------
`include "harmonic_grid_cell_update_top_defines.svh"

module hgc_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_vld,
    input  logic                                  i_tag,
    input  logic signed [hgc_pkg::NUM_W-1:0]      i_num,
    input  logic [hgc_pkg::XI_W-1:0]              i_den,
    output logic                                  o_vld,
    output logic                                  o_tag,
    output logic signed [hgc_pkg::DATA_W-1:0]     o_quo
);

    typedef struct packed {
        logic [hgc_pkg::NUM_W-1:0] rem;
        logic [hgc_pkg::QUO_W-1:0] quo;
        logic [hgc_pkg::XI_W-1:0]  den;
        logic                      neg;
        logic                      ovf;
        logic                      tag;
    } t_div_st;

    logic                      r_vld0, r_vld1;
    logic                      r_neg0, r_neg1, r_tag0, r_tag1;
    logic [hgc_pkg::NUM_W-1:0] r_mag0, r_u1;
    logic [hgc_pkg::XI_W-1:0]  r_den0, r_den1;

    t_div_st r_st  [0:hgc_pkg::QUO_W];
    logic    r_sv  [0:hgc_pkg::QUO_W];
    logic    r_vld_out, r_tag_out;
    logic signed [hgc_pkg::DATA_W-1:0] r_quo_out;
    logic signed [hgc_pkg::DATA_W-1:0] n_quo_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
            r_sv[0] <= 1'b0;
            r_vld_out <= 1'b0;
        end else begin
            r_vld0 <= i_vld;
            r_vld1 <= r_vld0;
            r_sv[0] <= r_vld1;
            r_vld_out <= r_sv[hgc_pkg::QUO_W];
        end
    end

    // Magnitude, then the rounding half-divisor, then the overflow test.
    always_ff @(posedge i_clk) begin
        r_neg0 <= i_num[hgc_pkg::NUM_W-1];
        r_mag0 <= i_num[hgc_pkg::NUM_W-1] ? (hgc_pkg::NUM_W'(0) - i_num) : i_num;
        r_den0 <= i_den;
        r_tag0 <= i_tag;
        r_u1   <= r_mag0 + hgc_pkg::NUM_W'(r_den0 >> 1);
        r_den1 <= r_den0;
        r_neg1 <= r_neg0;
        r_tag1 <= r_tag0;
        r_st[0].rem <= r_u1;
        r_st[0].quo <= '0;
        r_st[0].den <= r_den1;
        r_st[0].neg <= r_neg1;
        r_st[0].tag <= r_tag1;
        r_st[0].ovf <= {8'b0, r_u1} >= {r_den1, 32'b0};
    end

    for (genvar i = 0; i < hgc_pkg::QUO_W; i++) begin : g_step
        localparam int BIT = hgc_pkg::QUO_W - 1 - i;
        logic [hgc_pkg::WIDE_W-1:0] w_sh;
        logic                       w_take;
        t_div_st                    n_st;
        assign w_sh   = {32'b0, r_st[i].den} << BIT;
        assign w_take = {8'b0, r_st[i].rem} >= w_sh;

        always_comb begin
            n_st = r_st[i];
            if (w_take) begin
                n_st.rem = r_st[i].rem - w_sh[hgc_pkg::NUM_W-1:0];
                n_st.quo = r_st[i].quo | (hgc_pkg::QUO_W'(1) << BIT);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[i+1] <= 1'b0;
            end else begin
                r_sv[i+1] <= r_sv[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_st[i+1] <= n_st;
        end
    end

    always_comb begin
        n_quo_out = '0;
        if (r_st[hgc_pkg::QUO_W].neg) begin
            if (r_st[hgc_pkg::QUO_W].ovf || r_st[hgc_pkg::QUO_W].quo > 32'h80000000) begin
                n_quo_out = 32'sh80000000;
            end else begin
                n_quo_out = $signed(32'd0 - r_st[hgc_pkg::QUO_W].quo);
            end
        end else begin
            if (r_st[hgc_pkg::QUO_W].ovf || r_st[hgc_pkg::QUO_W].quo > 32'h7FFFFFFF) begin
                n_quo_out = 32'sh7FFFFFFF;
            end else begin
                n_quo_out = $signed(r_st[hgc_pkg::QUO_W].quo);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo_out <= n_quo_out;
        r_tag_out <= r_st[hgc_pkg::QUO_W].tag;
    end

    assign o_vld = r_vld_out;
    assign o_tag = r_tag_out;
    assign o_quo = r_quo_out;

    `HGC_ASSERT_IMPLY(a_div_first_bound, i_clk, i_rst_n, r_sv[0] && !r_st[0].ovf,
        {8'b0, r_st[0].rem} < {r_st[0].den, 32'b0})
    `HGC_ASSERT_IMPLY(a_div_last_rem, i_clk, i_rst_n,
        r_sv[hgc_pkg::QUO_W] && !r_st[hgc_pkg::QUO_W].ovf,
        {24'b0, r_st[hgc_pkg::QUO_W].rem} < {48'b0, r_st[hgc_pkg::QUO_W].den})
    `HGC_ASSERT_IMPLY(a_div_sign, i_clk, i_rst_n, r_vld_out && r_quo_out != 32'sd0,
        r_quo_out[hgc_pkg::DATA_W-1] == $past(r_st[hgc_pkg::QUO_W].neg))

endmodule

FILE: rtl/core/harmonic_grid_cell_update_top.sv
// ----------------------------------------------------------------------------
// Harmonic grid cell update
// Semi-implicit update of one cosine/sine harmonic cell in Q8.24.
// ----------------------------------------------------------------------------
//  channel   | ports                                        | direction
//  ----------+----------------------------------------------+----------
//  item      | i_start, o_busy, i_item                      | in
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_index/data   | in
//  result    | o_res_valid, o_res                           | out
//
// One word is taken every cycle while o_busy is low; each passes through the
// nine arithmetic stages and then the 36-stage divider, whose array resolves
// one quotient bit per stage.
// Reset is synchronous; o_busy is set during reset and cleared by the first
// clock edge after it is released.
// The result side cannot stall, so the pipeline advances on every clock.
// ----------------------------------------------------------------------------
`include "harmonic_grid_cell_update_top_defines.svh"

module harmonic_grid_cell_update_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  hgc_pkg::t_item                       i_item,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [hgc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [hgc_pkg::DATA_W-1:0]           i_cfg_data,
    output logic                                 o_res_valid,
    output hgc_pkg::t_res                        o_res
);

    // Configuration registers.
    logic r_busy;
    logic signed [31:0] r_e_dc, r_e_omega, r_b_field, r_gc;
    logic [hgc_pkg::DT_W-1:0] r_dt;
    logic signed [hgc_pkg::COS_W-1:0] r_cos_now, r_cos_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_e_dc     <= '0;
            r_e_omega  <= '0;
            r_b_field  <= '0;
            r_dt       <= hgc_pkg::DT_RESET;
            r_gc       <= '0;
            r_cos_now  <= hgc_pkg::COS_RESET;
            r_cos_next <= hgc_pkg::COS_RESET;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid) begin
                unique case (hgc_pkg::t_cfg_idx'(i_cfg_index))
                    hgc_pkg::CFG_E_DC:          r_e_dc     <= i_cfg_data;
                    hgc_pkg::CFG_E_OMEGA:       r_e_omega  <= i_cfg_data;
                    hgc_pkg::CFG_B_FIELD:       r_b_field  <= i_cfg_data;
                    hgc_pkg::CFG_TIME_STEP:     r_dt       <= i_cfg_data[hgc_pkg::DT_W-1:0];
                    hgc_pkg::CFG_GRID_COUPLING: r_gc       <= i_cfg_data;
                    hgc_pkg::CFG_COS_NOW:       r_cos_now  <= i_cfg_data[hgc_pkg::COS_W-1:0];
                    hgc_pkg::CFG_COS_NEXT:      r_cos_next <= i_cfg_data[hgc_pkg::COS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_cfg_ready = 1'b1;

    // Derived step constants: nu = 1 + dt/2 and nu tilde = 1 - dt/2.
    logic [hgc_pkg::DT_W-1:0] w_half;
    logic [25:0]              w_nu;
    logic [24:0]              w_nut;
    logic signed [25:0]       w_dt_s;
    logic signed [26:0]       w_nu_s;
    logic signed [25:0]       w_nut_s;

    assign w_half  = hgc_pkg::DT_W'((26'(r_dt) + 26'd1) >> 1);
    assign w_nu    = 26'd16777216 + 26'(w_half);
    assign w_nut   = 25'(26'd16777216 - 26'(w_half));
    assign w_dt_s  = $signed({1'b0, r_dt});
    assign w_nu_s  = $signed({1'b0, w_nu});
    assign w_nut_s = $signed({1'b0, w_nut});

    // Valid bits of the arithmetic stages.
    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r7_vld, r8_vld, r9_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0; r2_vld <= 1'b0; r3_vld <= 1'b0;
            r4_vld <= 1'b0; r5_vld <= 1'b0; r6_vld <= 1'b0;
            r7_vld <= 1'b0; r8_vld <= 1'b0; r9_vld <= 1'b0;
        end else begin
            r1_vld <= i_start && !r_busy;
            r2_vld <= r1_vld; r3_vld <= r2_vld; r4_vld <= r3_vld;
            r5_vld <= r4_vld; r6_vld <= r5_vld; r7_vld <= r6_vld;
            r8_vld <= r7_vld; r9_vld <= r8_vld;
        end
    end

    // Stage 1: input word.
    hgc_pkg::t_item r1_item;
    always_ff @(posedge i_clk) begin
        r1_item <= i_item;
    end

    // Stage 2: field products and the saturated neighbour differences.
    logic signed [57:0] r2_p_om_now, r2_p_om_next;
    logic signed [63:0] r2_p_bphi;
    logic signed [31:0] r2_db, r2_da, r2_a0, r2_ca, r2_cb;
    logic [hgc_pkg::HARM_W-1:0] r2_harm;
    logic signed [31:0] n2_db, n2_da;

    always_comb begin
        if (r1_item.harmonic[hgc_pkg::HARM_W-1:1] == '0) begin
            n2_db = r1_item.diff_b_upper;
        end else begin
            n2_db = hgc_pkg::sat32(72'(r1_item.diff_b_upper) - 72'(r1_item.diff_b_lower));
        end
        // The first harmonic takes its lower neighbour twice.
        priority if (r1_item.harmonic == '0) begin
            n2_da = hgc_pkg::sat32(72'sd0 - 72'(r1_item.diff_a_upper));
        end else if (r1_item.harmonic == 6'd1) begin
            n2_da = hgc_pkg::sat32((72'(r1_item.diff_a_lower) <<< 1)
                                   - 72'(r1_item.diff_a_upper));
        end else begin
            n2_da = hgc_pkg::sat32(72'(r1_item.diff_a_lower) - 72'(r1_item.diff_a_upper));
        end
    end

    always_ff @(posedge i_clk) begin
        r2_p_om_now  <= r_e_omega * r_cos_now;
        r2_p_om_next <= r_e_omega * r_cos_next;
        r2_p_bphi    <= r_b_field * r1_item.phi_coord;
        r2_db        <= n2_db;
        r2_da        <= n2_da;
        r2_a0        <= r1_item.source_amp;
        r2_ca        <= r1_item.cur_a;
        r2_cb        <= r1_item.cur_b;
        r2_harm      <= r1_item.harmonic;
    end

    // Stage 3: drift sums.
    logic signed [31:0] r3_s_now, r3_s_next, r3_db, r3_da, r3_a0, r3_ca, r3_cb;
    logic [hgc_pkg::HARM_W-1:0] r3_harm;

    always_ff @(posedge i_clk) begin
        r3_s_now  <= hgc_pkg::sat32(72'(r_e_dc) + hgc_pkg::rnd24(72'(r2_p_om_now))
                                    + hgc_pkg::rnd24(72'(r2_p_bphi)));
        r3_s_next <= hgc_pkg::sat32(72'(r_e_dc) + hgc_pkg::rnd24(72'(r2_p_om_next))
                                    + hgc_pkg::rnd24(72'(r2_p_bphi)));
        r3_db <= r2_db; r3_da <= r2_da;
        r3_a0 <= r2_a0; r3_ca <= r2_ca; r3_cb <= r2_cb;
        r3_harm <= r2_harm;
    end

    // Stage 4: drift times dt.
    logic signed [57:0] r4_p_now, r4_p_next;
    logic signed [31:0] r4_db, r4_da, r4_a0, r4_ca, r4_cb;
    logic [hgc_pkg::HARM_W-1:0] r4_harm;

    always_ff @(posedge i_clk) begin
        r4_p_now  <= r3_s_now * w_dt_s;
        r4_p_next <= r3_s_next * w_dt_s;
        r4_db <= r3_db; r4_da <= r3_da;
        r4_a0 <= r3_a0; r4_ca <= r3_ca; r4_cb <= r3_cb;
        r4_harm <= r3_harm;
    end

    // Stage 5: scale by the harmonic index.
    logic signed [33:0] w5_t_now, w5_t_next;
    logic signed [40:0] w5_m_now, w5_m_next;
    logic signed [6:0]  w5_n;
    logic signed [31:0] r5_mu0, r5_mu1, r5_db, r5_da, r5_a0, r5_ca, r5_cb;
    logic               r5_nz;

    assign w5_n      = $signed({1'b0, r4_harm});
    assign w5_t_now  = 34'(hgc_pkg::rnd25(72'(r4_p_now)));
    assign w5_t_next = 34'(hgc_pkg::rnd25(72'(r4_p_next)));
    assign w5_m_now  = w5_t_now * w5_n;
    assign w5_m_next = w5_t_next * w5_n;

    always_ff @(posedge i_clk) begin
        r5_mu0 <= hgc_pkg::sat32(72'(w5_m_now));
        r5_mu1 <= hgc_pkg::sat32(72'(w5_m_next));
        r5_db <= r4_db; r5_da <= r4_da;
        r5_a0 <= r4_a0; r5_ca <= r4_ca; r5_cb <= r4_cb;
        r5_nz <= r4_harm != '0;
    end

    // Stage 6: all products of g, h and the determinant.
    logic signed [63:0] r6_p_cb_mu0, r6_p_ca_mu0, r6_p_gc_db, r6_p_gc_da, r6_p_mu1sq;
    logic signed [57:0] r6_p_ca_nut, r6_p_cb_nut, r6_p_dt_a0;
    logic [51:0]        r6_p_nusq;
    logic signed [31:0] r6_mu1;
    logic               r6_nz;

    always_ff @(posedge i_clk) begin
        r6_p_cb_mu0 <= r5_cb * r5_mu0;
        r6_p_ca_mu0 <= r5_ca * r5_mu0;
        r6_p_gc_db  <= r_gc * r5_db;
        r6_p_gc_da  <= r_gc * r5_da;
        r6_p_mu1sq  <= r5_mu1 * r5_mu1;
        r6_p_ca_nut <= r5_ca * w_nut_s;
        r6_p_cb_nut <= r5_cb * w_nut_s;
        r6_p_dt_a0  <= w_dt_s * r5_a0;
        r6_p_nusq   <= w_nu * w_nu;
        r6_mu1      <= r5_mu1;
        r6_nz       <= r5_nz;
    end

    // Stage 7: g, h and the determinant xi.
    logic signed [31:0]        r7_g, r7_h, r7_mu1;
    logic [hgc_pkg::XI_W-1:0]  r7_xi;
    logic                      r7_nz;

    always_ff @(posedge i_clk) begin
        r7_g <= hgc_pkg::sat32(hgc_pkg::rnd24(72'(r6_p_dt_a0))
                               + hgc_pkg::rnd24(72'(r6_p_ca_nut))
                               - hgc_pkg::rnd24(72'(r6_p_cb_mu0))
                               + hgc_pkg::rnd24(72'(r6_p_gc_db)));
        r7_h <= hgc_pkg::sat32(hgc_pkg::rnd24(72'(r6_p_cb_nut))
                               + hgc_pkg::rnd24(72'(r6_p_ca_mu0))
                               + hgc_pkg::rnd24(72'(r6_p_gc_da)));
        r7_xi  <= hgc_pkg::XI_W'(hgc_pkg::rnd24($signed(72'(r6_p_nusq))
                                                + 72'(r6_p_mu1sq)));
        r7_mu1 <= r6_mu1;
        r7_nz  <= r6_nz;
    end

    // Stage 8: numerator products.
    logic signed [58:0] r8_g_nu, r8_h_nu;
    logic signed [63:0] r8_h_mu1, r8_g_mu1;
    logic [hgc_pkg::XI_W-1:0] r8_xi;
    logic                     r8_nz;

    always_ff @(posedge i_clk) begin
        r8_g_nu  <= r7_g * w_nu_s;
        r8_h_nu  <= r7_h * w_nu_s;
        r8_h_mu1 <= r7_h * r7_mu1;
        r8_g_mu1 <= r7_g * r7_mu1;
        r8_xi    <= r7_xi;
        r8_nz    <= r7_nz;
    end

    // Stage 9: numerators of the 2x2 solve.
    logic signed [hgc_pkg::NUM_W-1:0] r9_num_a, r9_num_b;
    logic [hgc_pkg::XI_W-1:0]         r9_xi;
    logic                             r9_nz;

    always_ff @(posedge i_clk) begin
        r9_num_a <= 64'(r8_g_nu) - r8_h_mu1;
        r9_num_b <= r8_g_mu1 + 64'(r8_h_nu);
        r9_xi    <= r8_xi;
        r9_nz    <= r8_nz;
    end

    logic w_a_vld, w_b_vld, w_a_tag, w_b_tag;
    logic signed [hgc_pkg::DATA_W-1:0] w_qa, w_qb;

    hgc_div u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r9_vld),
        .i_tag   (r9_nz),
        .i_num   (r9_num_a),
        .i_den   (r9_xi),
        .o_vld   (w_a_vld),
        .o_tag   (w_a_tag),
        .o_quo   (w_qa)
    );

    hgc_div u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r9_vld),
        .i_tag   (r9_nz),
        .i_num   (r9_num_b),
        .i_den   (r9_xi),
        .o_vld   (w_b_vld),
        .o_tag   (w_b_tag),
        .o_quo   (w_qb)
    );

    // The zeroth harmonic has no sine term.
    assign o_res_valid       = w_a_vld;
    assign o_res.new_a       = w_qa;
    assign o_res.new_b       = w_b_tag ? w_qb : '0;
    assign o_res.new_b_valid = w_b_tag;

    `HGC_ASSERT_ALWAYS(a_div_lockstep, i_clk, i_rst_n, w_a_vld == w_b_vld)
    `HGC_ASSERT_IMPLY(a_tag_match, i_clk, i_rst_n, w_a_vld, w_a_tag == w_b_tag)
    `HGC_ASSERT_IMPLY(a_sine_cleared, i_clk, i_rst_n, o_res_valid && !o_res.new_b_valid,
        o_res.new_b == '0)
    `HGC_ASSERT_IMPLY(a_xi_floor, i_clk, i_rst_n, r7_vld, r7_xi >= hgc_pkg::XI_MIN)

endmodule
